FILE: hw/rtl/poi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_pkg
// Shared types, widths and constants of the planar odometry integrator.
// ----------------------------------------------------------------------------
package poi_pkg;

  localparam int POS_W     = 32;   // Q16.16 position
  localparam int ANG_W     = 32;   // binary angle
  localparam int DT_W      = 20;   // elapsed time, 2^-16 s
  localparam int Q_W       = 16;   // Q1.15 quaternion term
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam int CRD_N     = 24;   // CORDIC iterations
  localparam int CRD_IDX_W = 5;
  localparam int CRD_XY_W  = 34;
  localparam int CRD_Z_W   = 33;

  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int STEP_W    = 40;   // rounded velocity * time step

  localparam logic signed [CRD_XY_W-1:0] CRD_START = 34'sd652032874;

  localparam logic signed [CFG_W-1:0] FWD_SPEED_RST = 32'sd6554;
  localparam logic signed [CFG_W-1:0] LAT_SPEED_RST = 32'sd0;
  localparam logic signed [CFG_W-1:0] TURN_RATE_RST = 32'sd34178264;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FWD_SPEED = 2'd0,
    REG_LAT_SPEED = 2'd1,
    REG_TURN_RATE = 2'd2
  } poi_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_V,
    ST_FIX_V,
    ST_MUL_0,
    ST_MUL_1,
    ST_MUL_2,
    ST_MUL_3,
    ST_MUL_4,
    ST_MUL_5,
    ST_MUL_6,
    ST_MUL_7,
    ST_MUL_8,
    ST_LOAD_Q,
    ST_ROT_Q,
    ST_FIN
  } poi_state_t;

  // arctan(2^-i) as a binary angle, 2^32 = 2*pi
  function automatic logic signed [CRD_Z_W-1:0] atan_entry(input logic [CRD_IDX_W-1:0] idx);
    logic signed [CRD_Z_W-1:0] v;
    unique case (idx)
      5'd0:    v = 33'sd536870912;
      5'd1:    v = 33'sd316933406;
      5'd2:    v = 33'sd167458907;
      5'd3:    v = 33'sd85004756;
      5'd4:    v = 33'sd42667331;
      5'd5:    v = 33'sd21354465;
      5'd6:    v = 33'sd10679838;
      5'd7:    v = 33'sd5340245;
      5'd8:    v = 33'sd2670163;
      5'd9:    v = 33'sd1335087;
      5'd10:   v = 33'sd667544;
      5'd11:   v = 33'sd333772;
      5'd12:   v = 33'sd166886;
      5'd13:   v = 33'sd83443;
      5'd14:   v = 33'sd41722;
      5'd15:   v = 33'sd20861;
      5'd16:   v = 33'sd10430;
      5'd17:   v = 33'sd5215;
      5'd18:   v = 33'sd2608;
      5'd19:   v = 33'sd1304;
      5'd20:   v = 33'sd652;
      5'd21:   v = 33'sd326;
      5'd22:   v = 33'sd163;
      5'd23:   v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/poi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_in_if / poi_out_if
// Valid/ready channels of the planar odometry integrator: tick in, pose out.
// ----------------------------------------------------------------------------
interface poi_in_if;
  import poi_pkg::*;

  logic            valid;
  logic            ready;
  logic [DT_W-1:0] elapsed_time;

  modport source(output valid, output elapsed_time, input ready);
  modport sink(input valid, input elapsed_time, output ready);
endinterface

interface poi_out_if;
  import poi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [ANG_W-1:0]        heading;
  logic signed [Q_W-1:0]   quat_z;
  logic signed [Q_W-1:0]   quat_w;
  logic                    position_clamped;

  modport source(output valid, output pos_x, output pos_y, output heading,
                 output quat_z, output quat_w, output position_clamped, input ready);
  modport sink(input valid, input pos_x, input pos_y, input heading,
               input quat_z, input quat_w, input position_clamped, output ready);
endinterface

FILE: hw/rtl/planar_odometry_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_odometry_integrator
// Dead-reckoning pose integrator: one tick in, one pose and yaw quaternion out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one tick item with the elapsed time since the last tick.
//   The body velocity (forward, lateral) is rotated by the heading, scaled by
//   the elapsed time and added to x/y (saturating), then the heading advances
//   by turn_rate * elapsed_time, wrapping modulo 4*pi.
//   out_ch returns one item per tick: x, y, heading, quaternion z/w, and a
//   clamp flag. cfg_we/cfg_index/cfg_wdata write the speed and turn-rate
//   registers; unknown indexes are dropped. Write them only while idle.
// Sequencing:
//   A tick passes through two 24-step passes of the single CORDIC rotator
//   (velocity angle, then quaternion angle) and nine steps of the one 34x32
//   multiplier. A result item becomes valid in the same cycle in which in_ch
//   is ready again; no new tick is taken before that.
// Reset / stall:
//   Reset clears the pose to zero and loads the default speeds. The result
//   sits in an output register; a new tick is taken while it waits, and the
//   block holds its last step until out_ch has taken the previous result.
// ----------------------------------------------------------------------------
module planar_odometry_integrator (
  input  logic                          clk,
  input  logic                          rst_n,
  poi_in_if.sink                        in_ch,
  poi_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [poi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [poi_pkg::CFG_W-1:0]     cfg_wdata
);
  import poi_pkg::*;

  // saturate a widened position sum, {hit, value}
  function automatic logic [POS_W:0] sat_pos(input logic signed [STEP_W:0] v);
    logic [POS_W:0] r;
    if (v > 41'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -41'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[POS_W-1:0]};
    end
    return r;
  endfunction

  // Q2.30 -> Q1.15, round half up, clamp
  function automatic logic signed [Q_W-1:0] to_q15(input logic signed [CRD_XY_W-1:0] v);
    logic signed [CRD_XY_W-1:0] r;
    logic signed [Q_W-1:0]      q;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) begin
      q = 16'sh7FFF;
    end else if (r < -34'sd32768) begin
      q = 16'sh8000;
    end else begin
      q = r[Q_W-1:0];
    end
    return q;
  endfunction

  poi_state_t state_r, state_nxt;

  logic signed [CFG_W-1:0]    fwd_r, lat_r, turn_r;
  logic signed [POS_W-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic [ANG_W-1:0]           head_r, head_nxt;
  logic                       clamp_r, clamp_nxt;
  logic [DT_W-1:0]            dt_r;

  logic signed [CRD_XY_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [CRD_Z_W-1:0]  cz_r, cz_nxt;
  logic                       flip_r, flip_nxt;
  logic [CRD_IDX_W-1:0]       iter_r, iter_nxt;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [PROD_W-1:0]   acc_r, acc_nxt;
  logic signed [MUL_A_W-1:0]  vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [STEP_W-1:0]   step_r, step_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0]    out_x_r, out_y_r;
  logic [ANG_W-1:0]           out_head_r;
  logic signed [Q_W-1:0]      out_qz_r, out_qw_r, out_qz_nxt, out_qw_nxt;
  logic                       out_clamp_r;

  logic                       in_ready;
  logic                       accept;
  logic                       out_load;
  logic                       crd_load;
  logic                       iter_last;
  logic [ANG_W-1:0]           load_angle;
  logic                       load_fold;
  logic signed [CRD_XY_W-1:0] sh_x, sh_y;
  logic signed [PROD_W-1:0]   acc_rnd, prod_rnd;
  logic signed [STEP_W:0]     pos_sum;
  logic [POS_W:0]             pos_sat;
  logic signed [CRD_XY_W-1:0] cos_v, sin_v;

  assign accept    = in_ch.valid && in_ready;
  assign iter_last = (iter_r == CRD_IDX_W'(CRD_N - 1));

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_ROT_V;
      ST_ROT_V:  if (iter_last) state_nxt = ST_FIX_V;
      ST_FIX_V:  state_nxt = ST_MUL_0;
      ST_MUL_0:  state_nxt = ST_MUL_1;
      ST_MUL_1:  state_nxt = ST_MUL_2;
      ST_MUL_2:  state_nxt = ST_MUL_3;
      ST_MUL_3:  state_nxt = ST_MUL_4;
      ST_MUL_4:  state_nxt = ST_MUL_5;
      ST_MUL_5:  state_nxt = ST_MUL_6;
      ST_MUL_6:  state_nxt = ST_MUL_7;
      ST_MUL_7:  state_nxt = ST_MUL_8;
      ST_MUL_8:  state_nxt = ST_LOAD_Q;
      ST_LOAD_Q: state_nxt = ST_ROT_Q;
      ST_ROT_Q:  if (iter_last) state_nxt = ST_FIN;
      ST_FIN:    if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    crd_load   = 1'b0;
    load_angle = {head_r[ANG_W-2:0], 1'b0};   // velocity uses 2*heading
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE:   crd_load = accept;
      ST_LOAD_Q: begin
        crd_load   = 1'b1;
        load_angle = head_r;
      end
      ST_FIN:    out_load = !out_valid_r || out_ch.ready;
      default:   ;
    endcase
  end

  // ---------------- CORDIC rotator ----------------
  assign load_fold = ($signed(load_angle) > 32'sh4000_0000) ||
                     ($signed(load_angle) < -32'sh4000_0000);
  assign sh_x = cx_r >>> iter_r;
  assign sh_y = cy_r >>> iter_r;

  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    cz_nxt   = cz_r;
    flip_nxt = flip_r;
    iter_nxt = iter_r;
    if (crd_load) begin
      cx_nxt   = CRD_START;
      cy_nxt   = '0;
      flip_nxt = load_fold;
      iter_nxt = '0;
      // fold by pi into [-pi/2, pi/2]
      cz_nxt   = load_fold ? CRD_Z_W'($signed({~load_angle[ANG_W-1], load_angle[ANG_W-2:0]}))
                           : CRD_Z_W'($signed(load_angle));
    end else if (state_r == ST_ROT_V || state_r == ST_ROT_Q) begin
      if (!cz_r[CRD_Z_W-1]) begin
        cx_nxt = cx_r - sh_y;
        cy_nxt = cy_r + sh_x;
        cz_nxt = cz_r - atan_entry(iter_r);
      end else begin
        cx_nxt = cx_r + sh_y;
        cy_nxt = cy_r - sh_x;
        cz_nxt = cz_r + atan_entry(iter_r);
      end
      iter_nxt = iter_last ? '0 : iter_r + CRD_IDX_W'(1);
    end else if (state_r == ST_FIX_V && flip_r) begin
      cx_nxt = -cx_r;
      cy_nxt = -cy_r;
    end
  end

  // ---------------- multiplier and accumulate ----------------
  always_comb begin
    mul_a = MUL_A_W'(fwd_r);
    mul_b = $signed({{(MUL_B_W - DT_W){1'b0}}, dt_r});
    unique case (state_r)
      ST_MUL_0: begin mul_a = MUL_A_W'(fwd_r); mul_b = $signed(cx_r[MUL_B_W-1:0]); end
      ST_MUL_1: begin mul_a = MUL_A_W'(lat_r); mul_b = $signed(cy_r[MUL_B_W-1:0]); end
      ST_MUL_2: begin mul_a = MUL_A_W'(fwd_r); mul_b = $signed(cy_r[MUL_B_W-1:0]); end
      ST_MUL_3: begin mul_a = MUL_A_W'(lat_r); mul_b = $signed(cx_r[MUL_B_W-1:0]); end
      ST_MUL_4: mul_a = vx_r;
      ST_MUL_6: mul_a = vy_r;
      ST_MUL_7: mul_a = MUL_A_W'(turn_r);
      default:  ;
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign acc_rnd  = (acc_r + (PROD_W'(1) <<< 29)) >>> 30;
  assign prod_rnd = (prod_r + (PROD_W'(1) <<< 15)) >>> 16;
  assign pos_sum  = (state_r == ST_MUL_6) ? (STEP_W + 1)'(x_r) + (STEP_W + 1)'(step_r)
                                          : (STEP_W + 1)'(y_r) + (STEP_W + 1)'(step_r);
  assign pos_sat  = sat_pos(pos_sum);

  always_comb begin
    acc_nxt   = acc_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    step_nxt  = step_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    head_nxt  = head_r;
    clamp_nxt = clamp_r;
    unique case (state_r)
      ST_IDLE:  if (accept) clamp_nxt = 1'b0;
      ST_MUL_1: acc_nxt = prod_r;
      ST_MUL_2: acc_nxt = acc_r - prod_r;
      ST_MUL_3: begin
        vx_nxt  = acc_rnd[MUL_A_W-1:0];
        acc_nxt = prod_r;
      end
      ST_MUL_4: acc_nxt = acc_r + prod_r;
      ST_MUL_5: begin
        vy_nxt   = acc_rnd[MUL_A_W-1:0];
        step_nxt = prod_rnd[STEP_W-1:0];
      end
      ST_MUL_6: begin
        x_nxt     = pos_sat[POS_W-1:0];
        clamp_nxt = clamp_r | pos_sat[POS_W];
      end
      ST_MUL_7: step_nxt = prod_rnd[STEP_W-1:0];
      ST_MUL_8: begin
        y_nxt     = pos_sat[POS_W-1:0];
        clamp_nxt = clamp_r | pos_sat[POS_W];
        head_nxt  = head_r + prod_rnd[ANG_W-1:0];   // wraps modulo 4*pi
      end
      default:  ;
    endcase
  end

  // ---------------- result ----------------
  assign cos_v      = flip_r ? -cx_r : cx_r;
  assign sin_v      = flip_r ? -cy_r : cy_r;
  assign out_qw_nxt = to_q15(cos_v);
  assign out_qz_nxt = to_q15(sin_v);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
      fwd_r       <= FWD_SPEED_RST;
      lat_r       <= LAT_SPEED_RST;
      turn_r      <= TURN_RATE_RST;
      x_r         <= '0;
      y_r         <= '0;
      head_r      <= '0;
      clamp_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      iter_r      <= iter_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      head_r      <= head_nxt;
      clamp_r     <= clamp_nxt;
      if (cfg_we) begin
        unique case (poi_reg_t'(cfg_index))
          REG_FWD_SPEED: fwd_r  <= $signed(cfg_wdata);
          REG_LAT_SPEED: lat_r  <= $signed(cfg_wdata);
          REG_TURN_RATE: turn_r <= $signed(cfg_wdata);
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dt_r <= in_ch.elapsed_time;
    end
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    flip_r <= flip_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    step_r <= step_nxt;
    if (out_load) begin
      out_x_r     <= x_r;
      out_y_r     <= y_r;
      out_head_r  <= head_r;
      out_qz_r    <= out_qz_nxt;
      out_qw_r    <= out_qw_nxt;
      out_clamp_r <= clamp_r;
    end
  end

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.pos_x            = out_x_r;
  assign out_ch.pos_y            = out_y_r;
  assign out_ch.heading          = out_head_r;
  assign out_ch.quat_z           = out_qz_r;
  assign out_ch.quat_w           = out_qw_r;
  assign out_ch.position_clamped = out_clamp_r;

  // ---------------- assertions ----------------
  a_iter_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ROT_V && state_r != ST_ROT_Q) |-> (iter_r == '0))
    else $error("CORDIC step count nonzero outside a rotation pass");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_ROT_V))
    else $error("accepted item did not start the velocity rotation");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ch.ready) |=> (state_r == ST_FIN))
    else $error("result written over an item not yet taken");

  a_pose_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |=> ($stable(head_r) && $stable(x_r) && $stable(y_r)))
    else $error("pose changed while idle");

endmodule

FILE: test/planar_odometry_integrator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_odometry_integrator_tb
// Self-checking bench for the dead-reckoning integrator. Each tick item is
// run through a local fixed-point predictor (CORDIC, rounding, saturation);
// each pose item that leaves the block is checked against the oldest
// prediction. Directed cases come first: defaults, zero and maximum elapsed
// time, register extremes with position saturation and heading wrap, and an
// unknown register index. Random ticks follow over several idle and
// backpressure mixes, with the speed and turn-rate registers reprogrammed while idle.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_tb;
  import poi_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;   // no register here
  localparam int     WATCHDOG_CYCLES = 3000;
  localparam int     DRAIN_CYCLES    = 100;
  localparam longint CRD_SEED        = 652032874;
  localparam longint QUARTER_TURN    = 1073741824;
  localparam logic [DT_W-1:0] DT_MAX = '1;
  localparam logic [CFG_W-1:0] REG_MAX = 32'h7fff_ffff;
  localparam logic [CFG_W-1:0] REG_MIN = 32'h8000_0000;

  localparam longint ATAN_STEP [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ANG_W-1:0]        heading;
    logic signed [Q_W-1:0]   quat_z;
    logic signed [Q_W-1:0]   quat_w;
    logic                    clamped;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  poi_in_if  in_ch();
  poi_out_if out_ch();

  planar_odometry_integrator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  longint     speed_fwd, speed_lat, yaw_rate;
  longint     odo_x, odo_y;
  logic [31:0] odo_heading;

  pose_t pending_poses[$];
  int    error_count  = 0;
  int    results_seen = 0;
  int    quiet_cycles = 0;
  int    send_idle_pct = 0;
  int    stall_pct     = 0;

  // --------------------------------------------------------------------------
  // fixed-point predictor
  // --------------------------------------------------------------------------
  function automatic longint round_shift(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  // cos/sin of a binary angle (2^32 = 2*pi), Q2.30
  function automatic void rotate_cordic(input logic [31:0] angle,
                                        output longint cos_v, output longint sin_v);
    longint      z, x, y, nx;
    logic [31:0] folded;
    bit          flip;
    int          i;
    z      = $signed(angle);
    x      = CRD_SEED;
    y      = 0;
    flip   = 1'b0;
    folded = angle + 32'h8000_0000;
    // fold into [-pi/2, pi/2] by a half turn, negate at the end
    if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
      z    = $signed(folded);
      flip = 1'b1;
    end
    for (i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_STEP[i];
      end
      x = nx;
    end
    cos_v = flip ? -x : x;
    sin_v = flip ? -y : y;
  endfunction

  function automatic longint clamp_pos(input longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [Q_W-1:0] to_q15(input longint v);
    longint r;
    r = round_shift(v, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[Q_W-1:0];
  endfunction

  function automatic pose_t integrate_tick(input logic [DT_W-1:0] dt);
    pose_t  p;
    longint dtl, c, s, vx, vy, dh, qz, qw;
    bit     hit;
    dtl = dt;
    hit = 1'b0;
    // velocity is rotated by the full heading: twice the half-angle word
    rotate_cordic({odo_heading[30:0], 1'b0}, c, s);
    vx = round_shift(speed_fwd * c - speed_lat * s, 30);
    vy = round_shift(speed_fwd * s + speed_lat * c, 30);
    odo_x = clamp_pos(odo_x + round_shift(vx * dtl, 16), hit);
    odo_y = clamp_pos(odo_y + round_shift(vy * dtl, 16), hit);
    dh = round_shift(yaw_rate * dtl, 16);
    odo_heading = odo_heading + dh[31:0];
    rotate_cordic(odo_heading, qw, qz);
    p.pos_x   = odo_x[31:0];
    p.pos_y   = odo_y[31:0];
    p.heading = odo_heading;
    p.quat_z  = to_q15(qz);
    p.quat_w  = to_q15(qw);
    p.clamped = hit;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // valid is left high on return; the next call or a drain lowers it
  task automatic send_tick(input logic [DT_W-1:0] dt);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.elapsed_time <= dt;
    do @(posedge clk); while (!in_ch.ready);
    pending_poses.push_back(integrate_tick(dt));
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FWD_SPEED: speed_fwd = $signed(val);
      REG_LAT_SPEED: speed_lat = $signed(val);
      REG_TURN_RATE: yaw_rate  = $signed(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DT_MAX;
      2, 3:    return DT_W'($urandom);
      default: return DT_W'($urandom_range(1, 13107));   // up to 0.2 s
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_reg_value(input int span_bits);
    case ($urandom_range(4))
      0:       return REG_MAX;
      1:       return REG_MIN;
      2:       return $urandom;
      default: return $urandom_range((1 << span_bits) - 1) - (1 << (span_bits - 1));
    endcase
  endfunction

  // receiver backpressure: bursts of stall cycles
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("MISMATCH result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    pose_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_poses.size() == 0) begin
        report_mismatch("pose item with nothing expected");
      end else begin
        want = pending_poses.pop_front();
        check_field("pos_x", out_ch.pos_x, want.pos_x);
        check_field("pos_y", out_ch.pos_y, want.pos_y);
        check_field("heading", out_ch.heading, want.heading);
        check_field("quat_z", out_ch.quat_z, want.quat_z);
        check_field("quat_w", out_ch.quat_w, want.quat_w);
        check_field("position_clamped", out_ch.position_clamped, want.clamped);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("TIMEOUT: %0d items still expected", pending_poses.size());
      $display("planar_odometry_integrator_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_tick('0);          // zero elapsed time repeats the reset pose
    send_tick(20'd6554);
    send_tick(20'd6554);
    send_tick(20'd1);
    send_tick(DT_MAX);
    send_tick('0);
    send_tick(20'd65536);
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_FWD_SPEED, REG_MAX);
    write_reg(REG_LAT_SPEED, '0);
    write_reg(REG_TURN_RATE, '0);
    send_tick(DT_MAX);      // x runs into the positive rail
    send_tick(DT_MAX);
    wait_for_results();
    write_reg(REG_FWD_SPEED, REG_MIN);
    write_reg(REG_LAT_SPEED, REG_MAX);
    write_reg(REG_TURN_RATE, REG_MAX);
    send_tick(DT_MAX);      // heading step wraps past 4*pi
    send_tick(DT_MAX);
    send_tick('0);
    wait_for_results();
    write_reg(REG_LAT_SPEED, REG_MIN);
    write_reg(REG_TURN_RATE, REG_MIN);
    send_tick(DT_MAX);
    send_tick(20'd1);
    wait_for_results();
    write_reg(REG_FWD_SPEED, '0);
    write_reg(REG_LAT_SPEED, '0);
    write_reg(REG_TURN_RATE, '0);
    send_tick(DT_MAX);
    wait_for_results();
  endtask

  task automatic test_unknown_index();
    write_reg(REG_FWD_SPEED, 32'sd6554);
    write_reg(REG_TURN_RATE, 32'sd34178264);
    write_reg(REG_UNUSED, '1);   // must be dropped
    send_tick(20'd6554);
    send_tick(20'd6554);
    wait_for_results();
    write_reg(REG_UNUSED, '0);
    send_tick(20'd32768);
    wait_for_results();
  endtask

  task automatic test_random_ticks(input int idle_pct, input int stall, input int n_items);
    int k;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (k = 0; k < n_items; k++) begin
      if (k % 60 == 0) begin
        wait_for_results();
        write_reg(REG_FWD_SPEED, rand_reg_value(20));
        write_reg(REG_LAT_SPEED, rand_reg_value(20));
        write_reg(REG_TURN_RATE, rand_reg_value(30));
        if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom);
      end
      send_tick(rand_dt());
    end
    wait_for_results();
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.elapsed_time <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    speed_fwd   = 6554;
    speed_lat   = 0;
    yaw_rate    = 34178264;
    odo_x       = 0;
    odo_y       = 0;
    odo_heading = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_unknown_index();
    test_random_ticks(0, 0, 190);
    test_random_ticks(62, 0, 190);
    test_random_ticks(0, 62, 190);
    test_random_ticks(12, 12, 190);

    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("planar_odometry_integrator_tb: clean");
    end else begin
      $display("planar_odometry_integrator_tb: errors");
    end
    $finish;
  end

endmodule
